/* rtl/core/swm_pkg.sv */
// swm_pkg: shared constants, state encoding and control/status structs for
// the sliding window median block.
// No dependencies.
package swm_pkg;

   localparam int unsigned SampleWidth      = 32;
   localparam int unsigned ResultWidth      = 33;
   localparam int unsigned CfgWidth         = 7;
   localparam int unsigned WindowMaxDefault = 64;

   localparam logic [CfgWidth-1:0] WindowSizeReset = 7'd3;

   typedef enum logic [2:0] {
      StIdle,
      StCheck,
      StInit,
      StSweep,
      StDrain,
      StEval,
      StDone
   } swm_state_type;

   typedef struct packed {
      logic accept;
      logic sweep_init;
      logic issue;
      logic eval;
      logic load_out;
   } swm_cmd_type;

   typedef struct packed {
      logic full;
      logic last_issue;
      logic both_found;
      logic out_free;
   } swm_status_type;

endpackage

/* rtl/core/swm_ram.sv */
// swm_ram: generic single write port RAM with one registered read port.
// Depends on nothing.
module swm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/swm_controller.sv */
// swm_controller: sequencer for the median search (per candidate: count sweep,
// then rank check). Depends on swm_pkg.
module swm_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  swm_pkg::swm_status_type status,
   output swm_pkg::swm_cmd_type    cmd
);

   import swm_pkg::*;

   swm_state_type state_ff;
   swm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               state_in = StCheck;
            end
         end
         StCheck: begin
            state_in = status.full ? StInit : StIdle;
         end
         StInit: begin
            state_in = status.both_found ? StDone : StSweep;
         end
         StSweep: begin
            if (status.last_issue) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            state_in = StEval;
         end
         StEval: begin
            state_in = StInit;
         end
         StDone: begin
            if (status.out_free) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == StIdle);
      cmd.accept     = (state_ff == StIdle) && req_valid;
      cmd.sweep_init = (state_ff == StInit);
      cmd.issue      = (state_ff == StSweep);
      cmd.eval       = (state_ff == StEval);
      cmd.load_out   = (state_ff == StDone) && status.out_free;
   end

endmodule

/* rtl/core/swm_datapath.sv */
// swm_datapath: sample ring (two RAM copies), rank counters, median selection
// and output register. Depends on swm_pkg and swm_ram.
module swm_datapath #(
   parameter int unsigned WINDOW_MAX = swm_pkg::WindowMaxDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swm_pkg::swm_cmd_type                  cmd,
   output swm_pkg::swm_status_type               status,
   input  logic signed [swm_pkg::SampleWidth-1:0] req_sample,
   input  logic                                  req_first_of_sequence,
   input  logic                                  csr_wr_en,
   input  logic [swm_pkg::CfgWidth-1:0]          csr_wr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [swm_pkg::ResultWidth-1:0] rsp_median_x2
);

   import swm_pkg::*;

   localparam int unsigned AW = $clog2(WINDOW_MAX);
   localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
   localparam logic [AW-1:0] LastAddr = AW'(WINDOW_MAX - 1);
   localparam logic [CW-1:0] WinMax   = CW'(WINDOW_MAX);

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LastAddr) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? LastAddr : p - AW'(1);
   endfunction

   logic [CfgWidth-1:0]   ws_ff,       ws_in;
   logic [AW-1:0]         wp_ff,       wp_in;
   logic [CW-1:0]         fill_ff,     fill_in;
   logic [AW-1:0]         head_ff,     head_in;
   logic [AW-1:0]         cand_ptr_ff, cand_ptr_in;
   logic [CW-1:0]         cand_idx_ff, cand_idx_in;
   logic [AW-1:0]         cmp_ptr_ff,  cmp_ptr_in;
   logic [CW-1:0]         cmp_cnt_ff,  cmp_cnt_in;
   logic                  pipe_v_ff,   pipe_v_in;
   logic [CW-1:0]         less_ff,     less_in;
   logic [CW-1:0]         eq_ff,       eq_in;
   logic                  found_lo_ff, found_lo_in;
   logic                  found_hi_ff, found_hi_in;
   logic [SampleWidth-1:0] lo_val_ff,  lo_val_in;
   logic [SampleWidth-1:0] hi_val_ff,  hi_val_in;
   logic                  out_valid_ff, out_valid_in;
   logic [ResultWidth-1:0] out_val_ff, out_val_in;

   logic [AW-1:0]          wr_addr;
   logic [CW-1:0]          fill_base;
   logic [CW-1:0]          weff;
   logic [CW-1:0]          rank_lo;
   logic [CW-1:0]          rank_hi;
   logic [CW:0]            upper;
   logic                   hit_lo;
   logic                   hit_hi;
   logic [SampleWidth-1:0] rd_cand;
   logic [SampleWidth-1:0] rd_cmp;

   swm_ram #(
      .WIDTH (SampleWidth),
      .DEPTH (WINDOW_MAX)
   ) u_ram_cand (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_addr (cand_ptr_ff),
      .rd_data (rd_cand)
   );

   swm_ram #(
      .WIDTH (SampleWidth),
      .DEPTH (WINDOW_MAX)
   ) u_ram_cmp (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_addr (cmp_ptr_ff),
      .rd_data (rd_cmp)
   );

   // effective window: zero acts as one, saturates at WINDOW_MAX
   always_comb begin
      if (ws_ff == '0) begin
         weff = CW'(1);
      end else if (32'(ws_ff) > 32'(WINDOW_MAX)) begin
         weff = WinMax;
      end else begin
         weff = CW'(ws_ff);
      end
      rank_lo = (weff - CW'(1)) >> 1;
      rank_hi = weff >> 1;
   end

   always_comb begin
      wr_addr   = req_first_of_sequence ? '0 : wp_ff;
      fill_base = req_first_of_sequence ? '0 : fill_ff;
      upper     = {1'b0, less_ff} + {1'b0, eq_ff};
      hit_lo    = (less_ff <= rank_lo) && ({1'b0, rank_lo} < upper);
      hit_hi    = (less_ff <= rank_hi) && ({1'b0, rank_hi} < upper);
   end

   always_comb begin
      ws_in        = csr_wr_en ? csr_wr_data : ws_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      cand_ptr_in  = cand_ptr_ff;
      cand_idx_in  = cand_idx_ff;
      found_lo_in  = found_lo_ff;
      found_hi_in  = found_hi_ff;
      lo_val_in    = lo_val_ff;
      hi_val_in    = hi_val_ff;
      if (cmd.accept) begin
         wp_in       = ptr_inc(wr_addr);
         fill_in     = (fill_base == WinMax) ? fill_base : fill_base + CW'(1);
         head_in     = wr_addr;
         cand_ptr_in = wr_addr;
         cand_idx_in = '0;
         found_lo_in = 1'b0;
         found_hi_in = 1'b0;
      end else if (cmd.eval) begin
         cand_ptr_in = ptr_dec(cand_ptr_ff);
         cand_idx_in = cand_idx_ff + CW'(1);
         if (hit_lo) begin
            found_lo_in = 1'b1;
            lo_val_in   = rd_cand;
         end
         if (hit_hi) begin
            found_hi_in = 1'b1;
            hi_val_in   = rd_cand;
         end
      end
   end

   always_comb begin
      cmp_ptr_in = cmp_ptr_ff;
      cmp_cnt_in = cmp_cnt_ff;
      less_in    = less_ff;
      eq_in      = eq_ff;
      pipe_v_in  = cmd.issue;
      if (cmd.sweep_init) begin
         cmp_ptr_in = head_ff;
         cmp_cnt_in = '0;
      end else if (cmd.issue) begin
         cmp_ptr_in = ptr_dec(cmp_ptr_ff);
         cmp_cnt_in = cmp_cnt_ff + CW'(1);
      end
      if (cmd.sweep_init) begin
         less_in = '0;
         eq_in   = '0;
      end else if (pipe_v_ff) begin
         less_in = less_ff + CW'($signed(rd_cmp) < $signed(rd_cand));
         eq_in   = eq_ff + CW'(rd_cmp == rd_cand);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_val_in   = out_val_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_val_in   = {lo_val_ff[SampleWidth-1], lo_val_ff}
                      + {hi_val_ff[SampleWidth-1], hi_val_ff};
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff        <= WindowSizeReset;
         wp_ff        <= '0;
         fill_ff      <= '0;
         pipe_v_ff    <= 1'b0;
         found_lo_ff  <= 1'b0;
         found_hi_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ws_ff        <= ws_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         pipe_v_ff    <= pipe_v_in;
         found_lo_ff  <= found_lo_in;
         found_hi_ff  <= found_hi_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      cand_ptr_ff <= cand_ptr_in;
      cand_idx_ff <= cand_idx_in;
      cmp_ptr_ff  <= cmp_ptr_in;
      cmp_cnt_ff  <= cmp_cnt_in;
      less_ff     <= less_in;
      eq_ff       <= eq_in;
      lo_val_ff   <= lo_val_in;
      hi_val_ff   <= hi_val_in;
      out_val_ff  <= out_val_in;
   end

   always_comb begin
      status.full       = (fill_ff >= weff);
      status.last_issue = (cmp_cnt_ff == weff - CW'(1));
      status.both_found = found_lo_ff && found_hi_ff;
      status.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_median_x2 = out_val_ff;

`ifndef SYNTH
   a_issue_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (cmp_cnt_ff < weff))
      else $error("compare sweep ran past the window");

   a_cand_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> (cand_idx_ff < weff))
      else $error("median not found within the window candidates");

   a_load_found: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (found_lo_ff && found_hi_ff))
      else $error("result loaded before both middle ranks were found");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= WinMax) && (wp_ff <= LastAddr))
      else $error("fill count or write pointer out of range");
`endif

endmodule

/* rtl/core/sliding_window_median.sv */
// Sliding window median: twice the median of the last W samples per request.
// A request that finds the window not yet full gives no result; otherwise the
// result goes to the output register after k = 1..W rank checks, each with a
// count sweep of one ring read per cycle. One request at a time.
// Reset (synchronous) clears control state and the window; ring RAM is not
// cleared, and no clearing pass is run.
module sliding_window_median #(
   parameter int unsigned WINDOW_MAX = swm_pkg::WindowMaxDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [swm_pkg::SampleWidth-1:0] req_sample,
   input  logic                                   req_first_of_sequence,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swm_pkg::ResultWidth-1:0] rsp_median_x2,
   input  logic                                   csr_wr_en,
   input  logic [swm_pkg::CfgWidth-1:0]           csr_wr_data
);

   import swm_pkg::*;

   swm_cmd_type    cmd;
   swm_status_type status;

   swm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_sample            (req_sample),
      .req_first_of_sequence (req_first_of_sequence),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_median_x2         (rsp_median_x2)
   );

endmodule
